// ----- rtl/clconv_pkg.sv -----
// Shared types, constants and helper functions for the clamped 2D convolution block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package clconv_pkg;

	// image and filter limits
	localparam int MAX_ROWS         = 256;
	localparam int MAX_COLS         = 256;
	localparam int MAX_FILTER_WIDTH = 9;
	localparam int COEFF_FRAC_BITS  = 14;

	// field widths
	localparam int ROW_W   = 8;
	localparam int COL_W   = 8;
	localparam int PIX_W   = 8;
	localparam int COEFF_W = 16;
	localparam int CMD_W   = 2;
	localparam int DIM_W   = 9;
	localparam int FW_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam int TAP_DEPTH   = MAX_FILTER_WIDTH * MAX_FILTER_WIDTH;
	localparam int TAP_W       = $clog2(TAP_DEPTH);
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int STORE_AW    = ROW_W + COL_W;
	localparam int COORD_W     = ROW_W + 2;
	localparam int PROD_W      = COEFF_W + PIX_W + 1;
	localparam int ACC_W       = PROD_W + TAP_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD_COEFF  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_PIXEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_WIDTH = 2'd2;

	// result status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_OUTSIDE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          col;
		logic [TAP_W-1:0]          tap_index;
		logic signed [COEFF_W-1:0] coeff_value;
		logic [PIX_W-1:0]          pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred_pixel;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic             wr_coeff;
		logic             wr_pixel;
		logic             clear_acc;
		logic             step;
		logic             finish;
		logic [FW_W-1:0]  y;
		logic [FW_W-1:0]  x;
		logic [TAP_W-1:0] tap;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             in_image;
		logic             tap_ok;
		logic [FW_W-1:0]  fw;
	} dp_stat_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [FW_W-1:0] sat_fw(input logic [FW_W-1:0] v);
		logic [FW_W-1:0] r;
		if (v == '0)
			r = FW_W'(1);
		else if (v > FW_W'(MAX_FILTER_WIDTH))
			r = FW_W'(MAX_FILTER_WIDTH);
		else
			r = v;
		return r;
	endfunction

	// clamp a window coordinate into 0..n-1
	function automatic logic [ROW_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] v,
		input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] last;
		logic [ROW_W-1:0] r;
		last = n - DIM_W'(1);
		if (v < 0)
			r = '0;
		else if (v >= $signed({1'b0, n}))
			r = last[ROW_W-1:0];
		else
			r = v[ROW_W-1:0];
		return r;
	endfunction

	// drop fraction bits and saturate to the pixel range
	function automatic logic [PIX_W-1:0] pixel_from_acc(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] q;
		logic [PIX_W-1:0] r;
		q = ACC_W'(acc) >> COEFF_FRAC_BITS;
		if (acc <= 0)
			r = '0;
		else if (q > ACC_W'((1 << PIX_W) - 1))
			r = '1;
		else
			r = q[PIX_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/clconv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module clconv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/clconv_ctrl.sv -----
// Controller of the clamped 2D convolution: decodes each command word and walks the
// filter window one tap a cycle. Depends on clconv_pkg.
`timescale 1ns / 1ps

module clconv_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  accept,
	input  clconv_pkg::dp_stat_t  stat,
	output clconv_pkg::ctl_cmd_t  cmd
);
	import clconv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic            busy_q;
	logic            drain_q;
	ctl_cmd_t        cmd_q;
	logic [FW_W-1:0] fw_last;

	assign accept  = start & ~busy_q;
	assign busy    = busy_q;
	assign cmd     = cmd_q;
	assign fw_last = stat.fw - FW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			drain_q <= 1'b0;
			cmd_q   <= '0;
		end else begin
			cmd_q.wr_coeff  <= 1'b0;
			cmd_q.wr_pixel  <= 1'b0;
			cmd_q.clear_acc <= 1'b0;
			cmd_q.finish    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
						busy_q  <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (stat.cmd == CMD_LOAD_COEFF) begin
						cmd_q.wr_coeff <= stat.tap_ok;
						state_q        <= ST_IDLE;
						busy_q         <= 1'b0;
					end else if (stat.cmd == CMD_WRITE_PIXEL) begin
						cmd_q.wr_pixel <= stat.in_image;
						state_q        <= ST_IDLE;
						busy_q         <= 1'b0;
					end else if (stat.cmd == CMD_COMPUTE) begin
						if (stat.in_image) begin
							cmd_q.clear_acc <= 1'b1;
							cmd_q.step      <= 1'b1;
							cmd_q.y         <= '0;
							cmd_q.x         <= '0;
							cmd_q.tap       <= '0;
							state_q         <= ST_RUN;
						end else begin
							cmd_q.finish <= 1'b1;
							state_q      <= ST_DONE;
						end
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					// advance across the row, then down
					if (cmd_q.x == fw_last) begin
						if (cmd_q.y == fw_last) begin
							cmd_q.step <= 1'b0;
							drain_q    <= 1'b0;
							state_q    <= ST_DRAIN;
						end else begin
							cmd_q.x   <= '0;
							cmd_q.y   <= cmd_q.y + FW_W'(1);
							cmd_q.tap <= cmd_q.tap + TAP_W'(1);
						end
					end else begin
						cmd_q.x   <= cmd_q.x + FW_W'(1);
						cmd_q.tap <= cmd_q.tap + TAP_W'(1);
					end
				end
				ST_DRAIN: begin
					// wait out the read and multiply stages
					if (drain_q) begin
						cmd_q.finish <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_DONE: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/clconv_dp.sv -----
// Datapath of the clamped 2D convolution: configuration registers, request register,
// frame and coefficient stores, multiply-accumulate pipeline and result register.
// Depends on clconv_pkg and clconv_ram.
`timescale 1ns / 1ps

module clconv_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [clconv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [clconv_pkg::DIM_W-1:0]       cfg_data,
	input  logic                               accept,
	input  clconv_pkg::req_t                   req,
	input  clconv_pkg::ctl_cmd_t               cmd,
	output clconv_pkg::dp_stat_t               stat,
	output logic                               rsp_valid,
	output clconv_pkg::rsp_t                   rsp
);
	import clconv_pkg::*;

	logic [DIM_W-1:0]          rows_q;
	logic [DIM_W-1:0]          cols_q;
	logic [FW_W-1:0]           fw_q;
	req_t                      req_q;
	logic                      in_image;
	logic [FW_W-1:0]           half;
	logic signed [COORD_W-1:0] row_off;
	logic signed [COORD_W-1:0] col_off;
	logic [ROW_W-1:0]          rd_row;
	logic [COL_W-1:0]          rd_col;
	logic [PIX_W-1:0]          pix_s1;
	logic [COEFF_W-1:0]        coeff_s1;
	logic                      valid_s1;
	logic                      valid_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	// configuration, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(MAX_ROWS);
			cols_q <= DIM_W'(MAX_COLS);
			fw_q   <= FW_W'(5);
		end else if (cfg_valid) begin
			if (cfg_index == REG_IMAGE_ROWS)
				rows_q <= sat_dim(cfg_data, DIM_W'(MAX_ROWS));
			else if (cfg_index == REG_IMAGE_COLS)
				cols_q <= sat_dim(cfg_data, DIM_W'(MAX_COLS));
			else if (cfg_index == REG_FILTER_WIDTH)
				fw_q <= sat_fw(cfg_data[FW_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req;
	end

	assign in_image = ({1'b0, req_q.row} < rows_q) && ({1'b0, req_q.col} < cols_q);

	assign stat.cmd      = req_q.cmd;
	assign stat.in_image = in_image;
	assign stat.tap_ok   = req_q.tap_index < TAP_W'(TAP_DEPTH);
	assign stat.fw       = fw_q;

	// window neighbour, clamped to the image
	assign half    = {1'b0, fw_q[FW_W-1:1]};
	assign row_off = $signed({2'b00, req_q.row}) + $signed(COORD_W'(cmd.y))
		- $signed(COORD_W'(half));
	assign col_off = $signed({2'b00, req_q.col}) + $signed(COORD_W'(cmd.x))
		- $signed(COORD_W'(half));
	assign rd_row  = clamp_coord(row_off, rows_q);
	assign rd_col  = clamp_coord(col_off, cols_q);

	clconv_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (cmd.wr_pixel),
		.waddr({req_q.row, req_q.col}),
		.wdata(req_q.pixel_in),
		.raddr({rd_row, rd_col}),
		.rdata(pix_s1)
	);

	clconv_ram #(
		.WIDTH(COEFF_W),
		.DEPTH(TAP_DEPTH)
	) u_coeff (
		.clk  (clk),
		.we   (cmd.wr_coeff),
		.waddr(req_q.tap_index),
		.wdata(req_q.coeff_value),
		.raddr(cmd.tap),
		.rdata(coeff_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coeff_s1) * $signed({1'b0, pix_s1});
		if (cmd.clear_acc)
			acc_q <= '0;
		else if (valid_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else
			rsp_valid_q <= cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.blurred_pixel <= in_image ? pixel_from_acc(acc_q) : '0;
			rsp_q.out_row       <= req_q.row;
			rsp_q.out_col       <= req_q.col;
			rsp_q.status        <= in_image ? STATUS_OK : STATUS_OUTSIDE;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/clamped_2d_convolution.sv -----
// Clamp-to-edge 2D convolution over an 8-bit frame store: top level.
// Instantiates clconv_ctrl and clconv_dp; depends on clconv_pkg.
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low. Loading a coefficient,
// writing a pixel or an unused command occupies the block only for its decode state. A
// query outside the image goes from its decode state to its done state and reads no store.
// A query inside the image walks the filter window one tap a cycle through the frame store
// read port and one multiplier, then waits out the read and multiply stages. For either query
// the next command word can be taken in the same cycle as its result word appears. The result
// word is on rsp for exactly one cycle, marked by rsp_valid; the receiver must take it then,
// as it cannot stall the block. Configuration writes are always taken (cfg_ready is tied high)
// and must only be issued while the block is idle. Neither store is cleared at reset.
module clamped_2d_convolution (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  clconv_pkg::req_t                 req,
	output logic                             rsp_valid,
	output clconv_pkg::rsp_t                 rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [clconv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clconv_pkg::DIM_W-1:0]     cfg_data
);
	import clconv_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;
	logic     accept;

	assign cfg_ready = 1'b1;

	clconv_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.accept(accept),
		.stat  (dp_stat),
		.cmd   (ctl_cmd)
	);

	clconv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.req      (req),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for clamped_2d_convolution: directed edge cases, then random command
// words under changing sender idling, each result checked against an in-bench filter.
// Depends on clconv_pkg and the RTL of the block.

module tb_top;
	import clconv_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	localparam int QUIET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 120;
	localparam int STALL_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	req_t                 req       = '0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 rsp_valid;
	rsp_t                 rsp;
	logic                 cfg_ready;

	// bench copy of the block state
	logic [PIX_W-1:0]          frame [STORE_DEPTH];
	bit                        pix_known [STORE_DEPTH];
	logic signed [COEFF_W-1:0] taps [TAP_DEPTH];
	bit                        tap_known [TAP_DEPTH];
	logic [DIM_W-1:0]          rows_reg = DIM_W'(MAX_ROWS);
	logic [DIM_W-1:0]          cols_reg = DIM_W'(MAX_COLS);
	logic [FW_W-1:0]           fw_reg   = FW_W'(5);

	rsp_t filtered_q [$];
	int   idle_pct     = 34;
	int   useful_words = 0;
	int   mismatches   = 0;
	int   stall_cycles = 0;

	clamped_2d_convolution u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic int limit_to(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pin_coord(int v, int n);
		if (v < 0)
			return 0;
		if (v >= n)
			return n - 1;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] convolve_at(int r0, int c0);
		int     n, half, nr, nc, r, c;
		longint acc;
		acc  = 0;
		nr   = limit_to(rows_reg, MAX_ROWS);
		nc   = limit_to(cols_reg, MAX_COLS);
		n    = limit_to(fw_reg, MAX_FILTER_WIDTH);
		half = n / 2;
		for (int y = 0; y < n; y++)
			for (int x = 0; x < n; x++) begin
				r = pin_coord(r0 + y - half, nr);
				c = pin_coord(c0 + x - half, nc);
				acc += longint'(taps[y * n + x]) * longint'({1'b0, frame[r * MAX_COLS + c]});
			end
		if (acc <= 0)
			return '0;
		acc = acc >>> COEFF_FRAC_BITS;
		if (acc > 255)
			return '1;
		return PIX_W'(acc);
	endfunction

	// advance the bench state by one accepted command word
	function automatic void filter_step(req_t w);
		int   nr, nc;
		rsp_t res;
		nr = limit_to(rows_reg, MAX_ROWS);
		nc = limit_to(cols_reg, MAX_COLS);
		case (w.cmd)
		CMD_LOAD_COEFF: begin
			if (int'(w.tap_index) < TAP_DEPTH) begin
				taps[w.tap_index]      = w.coeff_value;
				tap_known[w.tap_index] = 1'b1;
				useful_words++;
			end
		end
		CMD_WRITE_PIXEL: begin
			if (int'(w.row) < nr && int'(w.col) < nc) begin
				frame[int'(w.row) * MAX_COLS + int'(w.col)]     = w.pixel_in;
				pix_known[int'(w.row) * MAX_COLS + int'(w.col)] = 1'b1;
				useful_words++;
			end
		end
		CMD_COMPUTE: begin
			res.out_row = w.row;
			res.out_col = w.col;
			if (int'(w.row) < nr && int'(w.col) < nc) begin
				res.status        = STATUS_OK;
				res.blurred_pixel = convolve_at(w.row, w.col);
			end else begin
				res.status        = STATUS_OUTSIDE;
				res.blurred_pixel = '0;
			end
			filtered_q.push_back(res);
			useful_words++;
		end
		default: ;
		endcase
	endfunction

	function automatic req_t random_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t coeff_word(int tap, logic signed [COEFF_W-1:0] v);
		req_t w;
		w             = random_word();
		w.cmd         = CMD_LOAD_COEFF;
		w.tap_index   = TAP_W'(tap);
		w.coeff_value = v;
		return w;
	endfunction

	function automatic req_t pixel_word(int r, int c, logic [PIX_W-1:0] p);
		req_t w;
		w          = random_word();
		w.cmd      = CMD_WRITE_PIXEL;
		w.row      = ROW_W'(r);
		w.col      = COL_W'(c);
		w.pixel_in = p;
		return w;
	endfunction

	function automatic req_t query_word(int r, int c);
		req_t w;
		w     = random_word();
		w.cmd = CMD_COMPUTE;
		w.row = ROW_W'(r);
		w.col = COL_W'(c);
		return w;
	endfunction

	function automatic req_t spare_word();
		req_t w;
		w     = random_word();
		w.cmd = CMD_SPARE;
		return w;
	endfunction

	// scale small taps so that a full window sums near unity gain
	function automatic logic signed [COEFF_W-1:0] pick_coeff(int n_taps);
		case ($urandom_range(9))
		0: return COEFF_W'($urandom);
		1: return 16'sh7fff;
		2: return 16'sh8000;
		3: return -COEFF_W'($urandom_range(16384 / n_taps));
		default: return COEFF_W'($urandom_range(2 * 16384 / n_taps));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(11))
		0: return '0;
		1: return DIM_W'(MAX_ROWS);
		2: return DIM_W'(1);
		3: return DIM_W'($urandom_range(511, 257));
		4: return DIM_W'($urandom);
		5, 6: return DIM_W'($urandom_range(24, 1));
		default: return DIM_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_fw();
		case ($urandom_range(9))
		0: return '0;
		1: return DIM_W'($urandom_range(15, 10));
		2: return DIM_W'(MAX_FILTER_WIDTH);
		3: return {(DIM_W - FW_W)'($urandom), FW_W'($urandom_range(5, 1))};
		4: return DIM_W'($urandom_range(8, 6));
		default: return DIM_W'($urandom_range(5, 1));
		endcase
	endfunction

	function automatic int pick_coord(int n);
		case ($urandom_range(4))
		0: return 0;
		1: return n - 1;
		default: return $urandom_range(n - 1);
		endcase
	endfunction

	// hold start until the word is taken, then idle at random
	task automatic send_word(input req_t w);
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
		filter_step(w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req   <= random_word();
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_IMAGE_ROWS: rows_reg = data;
		REG_IMAGE_COLS: cols_reg = data;
		REG_FILTER_WIDTH: fw_reg = data[FW_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
		input logic [DIM_W-1:0] f);
		drain_results();
		write_reg(REG_IMAGE_ROWS, r);
		write_reg(REG_IMAGE_COLS, c);
		write_reg(REG_FILTER_WIDTH, f);
		cfg_valid <= 1'b0;
	endtask

	// fill every pixel and tap the window touches before it is read
	task automatic prep_window(input int r0, input int c0);
		int n, half, nr, nc, r, c;
		nr   = limit_to(rows_reg, MAX_ROWS);
		nc   = limit_to(cols_reg, MAX_COLS);
		n    = limit_to(fw_reg, MAX_FILTER_WIDTH);
		half = n / 2;
		for (int y = 0; y < n; y++)
			for (int x = 0; x < n; x++) begin
				r = pin_coord(r0 + y - half, nr);
				c = pin_coord(c0 + x - half, nc);
				if (!pix_known[r * MAX_COLS + c])
					send_word(pixel_word(r, c, PIX_W'($urandom)));
				if (!tap_known[y * n + x])
					send_word(coeff_word(y * n + x, pick_coeff(n * n)));
			end
	endtask

	task automatic query_at(input int r, input int c);
		if (r < limit_to(rows_reg, MAX_ROWS) && c < limit_to(cols_reg, MAX_COLS))
			prep_window(r, c);
		send_word(query_word(r, c));
	endtask

	task automatic reconfigure();
		int n;
		set_dims(pick_dim(), pick_dim(), pick_fw());
		n = limit_to(fw_reg, MAX_FILTER_WIDTH);
		for (int t = 0; t < n * n; t++)
			send_word(coeff_word(t, pick_coeff(n * n)));
	endtask

	task automatic test_coeff_table();
		for (int t = 0; t < TAP_DEPTH; t++)
			send_word(coeff_word(t, pick_coeff(25)));
		// taps past the table are dropped
		send_word(coeff_word(TAP_DEPTH, 16'sh7fff));
		send_word(coeff_word(127, 16'sh8000));
	endtask

	task automatic test_reset_window();
		send_word(pixel_word(0, 0, 8'hff));
		send_word(pixel_word(MAX_ROWS - 1, MAX_COLS - 1, 8'h00));
		send_word(pixel_word(0, 3, 8'h5a));
		query_at(0, 0);
		query_at(MAX_ROWS - 1, MAX_COLS - 1);
		query_at(0, MAX_COLS - 1);
		query_at(MAX_ROWS - 1, 0);
		query_at(128, 77);
	endtask

	task automatic test_outside_and_dropped();
		// zero sizes act as one
		set_dims('0, DIM_W'(1), '0);
		query_at(0, 0);
		query_at(1, 0);
		query_at(0, 1);
		query_at(255, 255);
		send_word(pixel_word(0, 3, 8'ha5));
		send_word(spare_word());
		drain_results();
		write_reg(REG_SPARE, '1);
		cfg_valid <= 1'b0;
		// oversized values clip to the maximum image and window
		set_dims(9'h1ff, 9'd300, 9'd15);
		query_at(0, 3);
		query_at(MAX_ROWS - 1, MAX_COLS - 1);
	endtask

	task automatic test_even_windows();
		set_dims(9'd6, 9'd7, 9'd4);
		query_at(0, 0);
		query_at(5, 6);
		query_at(2, 3);
		set_dims(9'd6, 9'd7, 9'd2);
		query_at(5, 6);
		query_at(0, 0);
		set_dims(9'd6, 9'd7, 9'd9);
		query_at(3, 3);
	endtask

	task automatic test_saturation();
		set_dims(9'd2, 9'd2, 9'd1);
		send_word(pixel_word(0, 0, 8'hff));
		send_word(pixel_word(1, 1, 8'h81));
		send_word(coeff_word(0, 16'sh7fff));
		query_at(0, 0);
		send_word(coeff_word(0, 16'sh8000));
		query_at(0, 0);
		send_word(coeff_word(0, 16'sh4000));
		query_at(1, 1);
		// half gain drops the fraction
		send_word(coeff_word(0, 16'sh2000));
		query_at(1, 1);
	endtask

	task automatic run_random(input int pct, input int count);
		int goal, next_cfg, pick, n, nr, nc, tap;
		idle_pct = pct;
		goal     = useful_words + count;
		next_cfg = useful_words;
		while (useful_words < goal) begin
			if (useful_words >= next_cfg) begin
				reconfigure();
				next_cfg = useful_words + $urandom_range(180, 60);
			end
			nr   = limit_to(rows_reg, MAX_ROWS);
			nc   = limit_to(cols_reg, MAX_COLS);
			n    = limit_to(fw_reg, MAX_FILTER_WIDTH);
			pick = $urandom_range(99);
			if (pick < 45)
				query_at(pick_coord(nr), pick_coord(nc));
			else if (pick < 55)
				query_at($urandom_range(255), $urandom_range(255));
			else if (pick < 75)
				send_word(pixel_word(pick_coord(nr), pick_coord(nc), PIX_W'($urandom)));
			else if (pick < 82)
				send_word(pixel_word($urandom_range(255), $urandom_range(255),
					PIX_W'($urandom)));
			else if (pick < 92) begin
				tap = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(n * n - 1);
				send_word(coeff_word(tap, pick_coeff(n * n)));
			end else if (pick < 97)
				send_word(spare_word());
			else
				drain_results();
		end
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (rsp_valid === 1'b1) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word at %0t: pixel %0d row %0d col %0d status %0d",
						$time, rsp.blurred_pixel, rsp.out_row, rsp.out_col, rsp.status);
			end else begin
				want = filtered_q.pop_front();
				if (rsp.blurred_pixel !== want.blurred_pixel || rsp.out_row !== want.out_row ||
					rsp.out_col !== want.out_col || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch at %0t: expected pixel %0d row %0d col %0d status %0d, %s",
							$time, want.blurred_pixel, want.out_row, want.out_col, want.status,
							$sformatf("got pixel %0d row %0d col %0d status %0d",
								rsp.blurred_pixel, rsp.out_row, rsp.out_col, rsp.status));
				end
			end
		end
		if ((start && !busy) || rsp_valid === 1'b1 || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coeff_table();
		test_reset_window();
		test_outside_and_dropped();
		test_even_windows();
		test_saturation();
		run_random(34, 500);
		run_random(66, 500);
		run_random(0, 500);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && filtered_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
